### sv/srit_pkg.sv
package srit_pkg;

  localparam int DEF_MAX_RUNS = 16;

  typedef enum logic [1:0] {
    OP_APPEND    = 2'd0,
    OP_TRANSLATE = 2'd1,
    OP_CONTAINS  = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_APP_MUL,
    S_APP_DO,
    S_TR_RD,
    S_TR_CMP,
    S_TR_MUL,
    S_TR_ADD,
    S_CO_RD,
    S_CO_CHK,
    S_CO_DIV
  } bstate_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] run_start;
    logic [31:0] run_length;
    logic [31:0] run_stride;
    logic [31:0] subset_position;
    logic [31:0] source_position;
  } cmd_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic [31:0] stride;
    logic [31:0] off;
  } entry_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
    logic [31:0] rem;
  } div_res_t;

endpackage

### sv/srit_ram.sv
module srit_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/srit_front.sv
module srit_front
  import srit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_run_start,
  input  logic [31:0] in_run_length,
  input  logic [31:0] in_run_stride,
  input  logic [31:0] in_subset_position,
  input  logic [31:0] in_source_position,
  output logic        q_valid,
  output cmd_t        q_cmd,
  input  logic        q_pop
);

  // two-word queue in front of the execution side
  cmd_t       slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  cmd_t       cmd_in;

  assign busy    = (count_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (count_r != 2'd0);
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    cmd_in.op              = op_t'(in_kind);
    cmd_in.run_start       = in_run_start;
    cmd_in.run_length      = in_run_length;
    cmd_in.run_stride      = in_run_stride;
    cmd_in.subset_position = in_subset_position;
    cmd_in.source_position = in_source_position;
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### sv/srit_div.sv
module srit_div
  import srit_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output div_res_t    res
);

  // restoring divider, one quotient bit a cycle
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[31:0], quo_r[31]};
    if (go) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r[31:0];

endmodule

### sv/srit_back.sv
module srit_back
  import srit_pkg::*;
#(
  parameter int MAX_RUNS = DEF_MAX_RUNS,
  localparam int IW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1,
  localparam int CW = $clog2(MAX_RUNS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  output logic [1:0]    out_status,
  output logic [31:0]   out_source_index,
  output logic          out_found,
  output logic [31:0]   out_total_count,
  output logic [CW-1:0] out_block_count,
  output logic          out_consecutive
);

  bstate_t     state_r, state_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] used_m1, idx_p1;
  logic [31:0] total_r, total_nxt;
  logic        first_one_r, first_one_nxt;
  entry_t      last_r, last_nxt;
  entry_t      pick_r, pick_nxt;
  logic [31:0] prod_r, prod_nxt;

  logic        ov_r, ov_nxt;
  status_t     st_r, st_nxt;
  logic [31:0] si_r, si_nxt;
  logic        fd_r, fd_nxt;
  logic [31:0] tc_r, tc_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic        cs_r, cs_nxt;

  logic        we;
  logic [IW-1:0] waddr;
  entry_t      wdata, rdata;
  logic        div_go;
  logic [31:0] div_a, div_b;
  div_res_t    div_res;

  logic [32:0] sum33, diff33, ndiff33;
  logic [31:0] reach;

  srit_ram #(.W($bits(entry_t)), .D(MAX_RUNS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (idx_r[IW-1:0]),
    .rdata (rdata)
  );

  srit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .res      (div_res)
  );

  assign used_m1 = used_r - CW'(1);
  assign idx_p1  = idx_r + CW'(1);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    total_nxt     = total_r;
    first_one_nxt = first_one_r;
    last_nxt      = last_r;
    pick_nxt      = pick_r;
    prod_nxt      = prod_r;
    ov_nxt        = 1'b0;
    st_nxt        = ST_OK;
    si_nxt        = '0;
    fd_nxt        = 1'b0;
    q_pop         = 1'b0;
    we            = 1'b0;
    waddr         = used_r[IW-1:0];
    wdata         = last_r;
    div_go        = 1'b0;
    sum33         = {1'b0, total_r} + {1'b0, cmd_r.run_length};
    reach         = last_r.start + prod_r;
    diff33        = {1'b0, cmd_r.source_position} - {1'b0, rdata.start};
    ndiff33       = -diff33;
    div_a         = diff33[32] ? ndiff33[31:0] : diff33[31:0];
    div_b         = rdata.stride[31] ? (~rdata.stride + 32'd1) : rdata.stride;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          case (q_cmd.op)
            OP_APPEND: state_nxt = S_APP_MUL;
            OP_TRANSLATE: begin
              if (q_cmd.subset_position >= total_r || used_r == '0) begin
                ov_nxt = 1'b1;
                st_nxt = ST_RANGE;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_TR_RD;
              end
            end
            OP_CONTAINS: begin
              if (used_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_CO_RD;
              end
            end
            default: begin
              used_nxt  = '0;
              total_nxt = '0;
              ov_nxt    = 1'b1;
            end
          endcase
        end
      end

      S_APP_MUL: begin
        prod_nxt  = last_r.len * cmd_r.run_stride;
        state_nxt = S_APP_DO;
      end

      S_APP_DO: begin
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
        if (cmd_r.run_length == '0) begin
          st_nxt = ST_EMPTY;
        end else if (sum33[32]) begin
          st_nxt = ST_FULL;
        end else if (used_r != '0 && last_r.stride == cmd_r.run_stride &&
                     reach == cmd_r.run_start) begin
          // run carries on the last entry
          last_nxt.len = last_r.len + cmd_r.run_length;
          we           = 1'b1;
          waddr        = used_m1[IW-1:0];
          wdata        = last_nxt;
          total_nxt    = sum33[31:0];
        end else if (used_r == CW'(MAX_RUNS)) begin
          st_nxt = ST_FULL;
        end else begin
          last_nxt.start  = cmd_r.run_start;
          last_nxt.len    = cmd_r.run_length;
          last_nxt.stride = cmd_r.run_stride;
          last_nxt.off    = total_r;
          we              = 1'b1;
          wdata           = last_nxt;
          used_nxt        = used_r + CW'(1);
          total_nxt       = sum33[31:0];
          if (used_r == '0) begin
            first_one_nxt = (cmd_r.run_stride == 32'd1);
          end
        end
      end

      S_TR_RD: state_nxt = S_TR_CMP;

      S_TR_CMP: begin
        // offsets rise strictly, so the last one not above wins
        if (rdata.off <= cmd_r.subset_position) begin
          pick_nxt = rdata;
        end
        idx_nxt   = idx_p1;
        state_nxt = (idx_p1 == used_r) ? S_TR_MUL : S_TR_RD;
      end

      S_TR_MUL: begin
        prod_nxt  = (cmd_r.subset_position - pick_r.off) * pick_r.stride;
        state_nxt = S_TR_ADD;
      end

      S_TR_ADD: begin
        si_nxt    = pick_r.start + prod_r;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      S_CO_RD: state_nxt = S_CO_CHK;

      S_CO_CHK: begin
        pick_nxt = rdata;
        if (rdata.stride == '0 || diff33 == '0 || diff33[32] != rdata.stride[31]) begin
          // decided without dividing: zero stride, zero distance or wrong sign
          if ((rdata.stride == '0 && rdata.start == cmd_r.source_position) ||
              (rdata.stride != '0 && diff33 == '0)) begin
            ov_nxt    = 1'b1;
            fd_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (idx_p1 == used_r) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_CO_RD;
          end
        end else begin
          div_go    = 1'b1;
          state_nxt = S_CO_DIV;
        end
      end

      S_CO_DIV: begin
        if (div_res.done) begin
          if (div_res.rem == '0 && div_res.quot < pick_r.len) begin
            ov_nxt    = 1'b1;
            fd_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else if (idx_p1 == used_r) begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_p1;
            state_nxt = S_CO_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    tc_nxt = total_nxt;
    bc_nxt = used_nxt;
    cs_nxt = (used_nxt == '0) || (used_nxt == CW'(1) && first_one_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      total_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      total_r <= total_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    first_one_r <= first_one_nxt;
    last_r      <= last_nxt;
    pick_r      <= pick_nxt;
    prod_r      <= prod_nxt;
    if (ov_nxt) begin
      st_r <= st_nxt;
      si_r <= si_nxt;
      fd_r <= fd_nxt;
      tc_r <= tc_nxt;
      bc_r <= bc_nxt;
      cs_r <= cs_nxt;
    end
  end

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_source_index = si_r;
  assign out_found        = fd_r;
  assign out_total_count  = tc_r;
  assign out_block_count  = bc_r;
  assign out_consecutive  = cs_r;

endmodule

### sv/strided_run_index_table.sv
// channel   ports                          handshake
// input     in_* (six fields)              start & !busy
// result    out_* (six fields)             out_valid, one cycle
//
// Back end steps from pop to decision; the result word appears in the cycle after.
// Clear, empty-table and out-of-range words are decided at the pop. Append: pop,
// multiply for the reach, then decide and write. Translate: pop, a read and a
// compare per entry in use, then multiply and add. Contains: pop, then a read and a
// check per entry examined, plus the bit-serial divider for each entry that needs it.
// Synchronous active-low reset empties queue and table. The two-word
// queue raises busy when full; results cannot be stalled.
module strided_run_index_table
  import srit_pkg::*;
#(
  parameter int MAX_RUNS = DEF_MAX_RUNS,
  localparam int CW = $clog2(MAX_RUNS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_run_start,
  input  logic [31:0]        in_run_length,
  input  logic signed [31:0] in_run_stride,
  input  logic [31:0]        in_subset_position,
  input  logic [31:0]        in_source_position,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_source_index,
  output logic               out_found,
  output logic [31:0]        out_total_count,
  output logic [CW-1:0]      out_block_count,
  output logic               out_consecutive
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  srit_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_run_start       (in_run_start),
    .in_run_length      (in_run_length),
    .in_run_stride      (in_run_stride),
    .in_subset_position (in_subset_position),
    .in_source_position (in_source_position),
    .q_valid            (q_valid),
    .q_cmd              (q_cmd),
    .q_pop              (q_pop)
  );

  srit_back #(.MAX_RUNS(MAX_RUNS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_source_index (out_source_index),
    .out_found        (out_found),
    .out_total_count  (out_total_count),
    .out_block_count  (out_block_count),
    .out_consecutive  (out_consecutive)
  );

endmodule

### sv/srit_checker.sv
module srit_checker
  import srit_pkg::*;
#(
  parameter int MAX_RUNS = DEF_MAX_RUNS,
  localparam int CW = $clog2(MAX_RUNS + 1)
) (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic [1:0]    out_status,
  input logic [31:0]   out_source_index,
  input logic          out_found,
  input logic [31:0]   out_total_count,
  input logic [CW-1:0] out_block_count,
  input logic          out_consecutive
);

  a_empty_consec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_count == '0 |-> out_consecutive)
    else $error("empty table not reported consecutive");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_block_count == '0 |-> out_total_count == '0)
    else $error("elements counted with no entries");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK && out_source_index == '0)
    else $error("hit reported with bad status or index");

  a_bad_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_source_index == '0 && !out_found)
    else $error("failed word carries a result");

  a_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_block_count <= CW'(MAX_RUNS))
    else $error("block count beyond table size");

endmodule

bind strided_run_index_table srit_checker #(.MAX_RUNS(MAX_RUNS)) u_srit_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_source_index (out_source_index),
  .out_found        (out_found),
  .out_total_count  (out_total_count),
  .out_block_count  (out_block_count),
  .out_consecutive  (out_consecutive)
);

### test/strided_run_index_table_chk.sv
module strided_run_index_table_chk
  import srit_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [31:0]        in_run_start,
  input  logic [31:0]        in_run_length,
  input  logic [31:0]        in_run_stride,
  input  logic [31:0]        in_subset_position,
  input  logic [31:0]        in_source_position,
  input  logic               out_valid,
  input  logic [1:0]         out_status,
  input  logic [31:0]        out_source_index,
  input  logic               out_found,
  input  logic [31:0]        out_total_count,
  input  logic [4:0]         out_block_count,
  input  logic               out_consecutive,
  output int                 errors,
  output int                 pending,
  output logic               accepted
);

  typedef struct packed {
    status_t     status;
    logic [31:0] src_idx;
    logic        found;
    logic [31:0] total_count;
    logic [4:0]  block_count;
    logic        consecutive;
  } word_t;

  entry_t      runs[DEF_MAX_RUNS];
  int unsigned used;
  logic [31:0] total;
  word_t       expected_words[$];

  assign pending = expected_words.size();
  assign accepted = (start && !busy) || out_valid;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic status_t append_run(logic [31:0] st, logic [31:0] len, logic [31:0] sd);
    logic [31:0] reach;
    if (len == 0) return ST_EMPTY;
    if ({32'd0, total} + {32'd0, len} > 64'hFFFF_FFFF) return ST_FULL;
    if (used > 0) begin
      reach = runs[used-1].start + runs[used-1].len * sd;
      if (runs[used-1].stride == sd && reach == st) begin
        runs[used-1].len += len;
        total += len;
        return ST_OK;
      end
    end
    if (used >= DEF_MAX_RUNS) return ST_FULL;
    runs[used] = '{start: st, len: len, stride: sd, off: total};
    used++;
    total += len;
    return ST_OK;
  endfunction

  function automatic logic hits_source(logic [31:0] src);
    longint step, diff;
    for (int i = 0; i < used; i++) begin
      step = longint'($signed(runs[i].stride));
      if (step == 0) begin
        if (runs[i].start == src) return 1'b1;
      end else begin
        diff = longint'({32'd0, src}) - longint'({32'd0, runs[i].start});
        if (diff % step == 0 && diff / step >= 0 && diff / step < longint'({32'd0, runs[i].len}))
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic word_t predict_word(op_t op, logic [31:0] st, logic [31:0] len,
                                         logic [31:0] sd, logic [31:0] spos, logic [31:0] srcp);
    word_t w;
    int pick;
    w = '0;
    case (op)
      OP_APPEND: w.status = append_run(st, len, sd);
      OP_TRANSLATE: begin
        if (spos >= total || used == 0) w.status = ST_RANGE;
        else begin
          pick = 0;
          for (int i = 0; i < used; i++) if (runs[i].off <= spos) pick = i;
          w.src_idx = runs[pick].start + runs[pick].stride * (spos - runs[pick].off);
        end
      end
      OP_CONTAINS: w.found = hits_source(srcp);
      default: begin
        used = 0;
        total = 0;
      end
    endcase
    w.total_count = total;
    w.block_count = used[4:0];
    w.consecutive = (used == 0) || (used == 1 && runs[0].stride == 32'd1);
    return w;
  endfunction

  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      used = 0;
      total = 0;
      errors = 0;
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $display("unexpected result word at %0t", $time);
          errors++;
        end else begin
          w = expected_words.pop_front();
          if (out_status != w.status) report("status", out_status, w.status);
          if (out_source_index != w.src_idx)
            report("index", out_source_index, w.src_idx);
          if (out_found != w.found) report("found", out_found, w.found);
          if (out_total_count != w.total_count)
            report("total_count", out_total_count, w.total_count);
          if (out_block_count != w.block_count)
            report("block_count", out_block_count, w.block_count);
          if (out_consecutive != w.consecutive)
            report("consecutive", out_consecutive, w.consecutive);
        end
      end
      if (start && !busy)
        expected_words = {expected_words,
                          predict_word(op_t'(in_kind), in_run_start, in_run_length,
                                       in_run_stride, in_subset_position,
                                       in_source_position)};
    end
  end

endmodule

### test/strided_run_index_table_tb.sv
module strided_run_index_table_tb;
  import srit_pkg::*;

  logic clk = 0, rst_n = 0, start = 0, busy;
  logic [1:0] in_kind = 0;
  logic [31:0] in_run_start = 0, in_run_length = 0, in_run_stride = 0;
  logic [31:0] in_subset_position = 0, in_source_position = 0;
  logic out_valid, out_found, out_consecutive;
  logic [1:0] out_status;
  logic [31:0] out_source_index, out_total_count;
  logic [4:0] out_block_count;
  int errors, pending;
  logic accepted;
  int idle_cycles = 0;

  localparam int WATCHDOG = 20000;

  always #4 clk = ~clk;

  strided_run_index_table u_top (.*);

  strided_run_index_table_chk u_chk (.*);

  // runs in progress: next start keeps a chain going so extensions happen
  logic [31:0] chain_next, chain_stride;

  task automatic send_word(op_t op, logic [31:0] st, logic [31:0] len, logic [31:0] sd,
                           logic [31:0] spos, logic [31:0] srcp);
    in_kind = op;
    in_run_start = st;
    in_run_length = len;
    in_run_stride = sd;
    in_subset_position = spos;
    in_source_position = srcp;
    start = 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    start = 0;
  endtask

  task automatic gap();
    int n;
    n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_word();
    logic [31:0] st, len, sd, tot;
    int r;
    r = $urandom_range(0, 99);
    tot = out_total_count;
    if (r < 45) begin
      sd = ($urandom_range(0, 3) == 0) ? pick32() : $signed($urandom_range(0, 10)) - 5;
      len = ($urandom_range(0, 9) == 0) ? pick32() : $urandom_range(0, 20);
      if ($urandom_range(0, 2) == 0) begin
        st = chain_next;
        sd = chain_stride;
      end else st = ($urandom_range(0, 1)) ? pick32() : $urandom_range(0, 200);
      chain_next = st + len * sd;
      chain_stride = sd;
      send_word(OP_APPEND, st, len, sd, pick32(), pick32());
    end else if (r < 68) begin
      send_word(OP_TRANSLATE, pick32(), pick32(), pick32(),
                ($urandom_range(0, 4) == 0 || tot == 0) ? pick32()
                                                      : $urandom_range(0, tot - 1),
                pick32());
    end else if (r < 94) begin
      send_word(OP_CONTAINS, pick32(), pick32(), pick32(), pick32(),
                ($urandom_range(0, 1)) ? pick32() : $urandom_range(0, 300));
    end else begin
      send_word(OP_CLEAR, pick32(), pick32(), pick32(), pick32(), pick32());
    end
  endtask

  // watchdog: cycles with no word moving either way
  always @(posedge clk) begin
    if (accepted || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("strided_run_index_table_tb: done, errors");
      $finish;
    end
  end

  initial begin
    chain_next = 0;
    chain_stride = 1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    // directed
    send_word(OP_CONTAINS, 0, 0, 0, 0, 5);
    send_word(OP_TRANSLATE, 0, 0, 0, 0, 0);
    send_word(OP_APPEND, 10, 0, 1, 0, 0);
    send_word(OP_APPEND, 10, 5, 1, 0, 0);
    send_word(OP_APPEND, 15, 3, 1, 0, 0);
    send_word(OP_TRANSLATE, 0, 0, 0, 7, 0);
    send_word(OP_TRANSLATE, 0, 0, 0, 8, 0);
    send_word(OP_APPEND, 100, 4, 0, 0, 0);
    send_word(OP_APPEND, 32'hFFFF_FFF0, 6, 32'h8000_0000, 0, 0);
    send_word(OP_APPEND, 50, 10, 32'hFFFF_FFFD, 0, 0);
    send_word(OP_CONTAINS, 0, 0, 0, 0, 100);
    send_word(OP_CONTAINS, 0, 0, 0, 0, 101);
    send_word(OP_CONTAINS, 0, 0, 0, 0, 23);
    send_word(OP_CONTAINS, 0, 0, 0, 0, 32'hFFFF_FFFF);
    send_word(OP_TRANSLATE, 0, 0, 0, 20, 0);
    send_word(OP_APPEND, 0, 32'hFFFF_FFFF, 1, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0);
    send_word(OP_APPEND, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_word(OP_TRANSLATE, 0, 0, 0, 32'hFFFF_FFFE, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0);
    for (int i = 0; i < 17; i++) send_word(OP_APPEND, i * 7, 2, 1, 0, 0);
    send_word(OP_CONTAINS, 0, 0, 0, 0, 112);
    send_word(OP_CLEAR, 0, 0, 0, 0, 0);
    // random
    for (int i = 0; i < 1000; i++) begin
      if (i == 500) begin
        // hold off until the block has drained
        while (pending != 0) @(negedge clk);
      end
      gap();
      random_word();
    end
    while (pending != 0) @(negedge clk);
    repeat (600) @(negedge clk);
    if (errors == 0 && pending == 0) $display("strided_run_index_table_tb: done, clean");
    else $display("strided_run_index_table_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
sv/srit_pkg.sv
sv/srit_ram.sv
sv/srit_front.sv
sv/srit_div.sv
sv/srit_back.sv
sv/strided_run_index_table.sv
sv/srit_checker.sv
test/strided_run_index_table_chk.sv
test/strided_run_index_table_tb.sv
